[design/iee_pkg.sv]
// Shared types, character codes and helpers for the infix expression evaluator.
// No dependencies; used by iee_front, iee_back and infix_expression_evaluator.
package iee_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_POW    = 8'h5E;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_OPEN,
    TK_CLOSE,
    TK_OP,
    TK_BAD
  } tok_kind_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_MALFORMED = 2'd1,
    STS_DIV0      = 2'd2,
    STS_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    tok_kind_e   kind;
    op_e         op;
    logic [3:0]  digit;
    logic        last;
  } token_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_END,
    ST_CLOSE,
    ST_OPSCAN,
    ST_FIN,
    ST_RESULT,
    ST_RED0,
    ST_RED1,
    ST_RED2,
    ST_DIV,
    ST_DIVFIN,
    ST_POW,
    ST_WR
  } state_e;

  function automatic logic [1:0] prec_of(op_e op);
    logic [1:0] p;
    unique case (op)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

[design/iee_front.sv]
// Front end: classifies each input character into a token and queues it.
// Depends on iee_pkg. Two-entry queue toward iee_back.
module iee_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            sym_valid_i,
  output logic            sym_stall_o,
  input  logic [7:0]      symbol_i,
  input  logic            end_of_expression_i,
  output logic            tok_valid_o,
  input  logic            tok_pop_i,
  output iee_pkg::token_t tok_o
);

  iee_pkg::token_t tok_new;
  iee_pkg::token_t ent_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  always_comb begin
    tok_new.kind  = iee_pkg::TK_BAD;
    tok_new.op    = iee_pkg::OP_OPEN;
    tok_new.digit = symbol_i[3:0];
    tok_new.last  = end_of_expression_i;
    priority if (symbol_i >= iee_pkg::CH_0 && symbol_i <= iee_pkg::CH_9) begin
      tok_new.kind = iee_pkg::TK_DIGIT;
    end else if (symbol_i == iee_pkg::CH_OPEN) begin
      tok_new.kind = iee_pkg::TK_OPEN;
    end else if (symbol_i == iee_pkg::CH_CLOSE) begin
      tok_new.kind = iee_pkg::TK_CLOSE;
    end else if (symbol_i == iee_pkg::CH_ADD) begin
      tok_new.kind = iee_pkg::TK_OP;
      tok_new.op   = iee_pkg::OP_ADD;
    end else if (symbol_i == iee_pkg::CH_SUB) begin
      tok_new.kind = iee_pkg::TK_OP;
      tok_new.op   = iee_pkg::OP_SUB;
    end else if (symbol_i == iee_pkg::CH_MUL) begin
      tok_new.kind = iee_pkg::TK_OP;
      tok_new.op   = iee_pkg::OP_MUL;
    end else if (symbol_i == iee_pkg::CH_DIV) begin
      tok_new.kind = iee_pkg::TK_OP;
      tok_new.op   = iee_pkg::OP_DIV;
    end else if (symbol_i == iee_pkg::CH_POW) begin
      tok_new.kind = iee_pkg::TK_OP;
      tok_new.op   = iee_pkg::OP_POW;
    end else begin
      tok_new.kind = iee_pkg::TK_BAD;
    end
  end

  assign sym_stall_o = (cnt_q == 2'd2);
  assign push        = sym_valid_i && !sym_stall_o;
  assign tok_valid_o = (cnt_q != 2'd0);
  assign pop         = tok_pop_i && tok_valid_o;
  assign tok_o       = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= tok_new;
  end

endmodule

[design/iee_back.sv]
// Back end: value and operator stacks, precedence sequencer, shared multiplier,
// bit-serial divider and square-and-multiply power. Depends on iee_pkg.
module iee_back #(
  parameter int unsigned STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    tok_valid_i,
  output logic                    tok_pop_o,
  input  iee_pkg::token_t         tok_i,
  output logic                    res_valid_o,
  input  logic                    res_stall_i,
  output logic signed [31:0]      result_value_o,
  output logic [1:0]              status_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] FULL  = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE   = CW'(1);
  localparam logic [CW-1:0] TWO   = CW'(2);
  localparam logic [4:0] DIV_LAST = 5'd31;
  localparam logic [4:0] POW_LAST = 5'd30;

  iee_pkg::state_e  state_q, state_d, ret_q, ret_d;
  iee_pkg::status_e err_q, err_d, res_sts_q, res_sts_d;
  iee_pkg::token_t  tok_q, tok_d;
  iee_pkg::op_e     opc_q, opc_d, otop_q;
  logic [CW-1:0]    vcnt_q, vcnt_d, ocnt_q, ocnt_d;
  logic             out_valid_q, out_valid_d;
  logic [31:0]      res_val_q, res_val_d;

  logic [31:0] b_q, b_d, r_q, r_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d, base_q, base_d, e_q, e_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        phase_q, phase_d;

  logic [31:0] vmem [STACK_DEPTH];
  iee_pkg::op_e omem [STACK_DEPTH];
  logic [31:0] vrd_q;
  logic          v_we, o_we, o_ld, o_byp;
  logic [AW-1:0] v_waddr, v_raddr, o_waddr, o_raddr;
  logic [31:0]   v_wdata;
  iee_pkg::op_e  o_wdata;

  logic [CW-1:0] vtop1, vtop2, otop2;
  logic [31:0]   mul_x, mul_y, prod;
  logic [32:0]   sh, diff;
  logic          do_reduce;

  assign vtop1 = vcnt_q - ONE;
  assign vtop2 = vcnt_q - TWO;
  assign otop2 = ocnt_q - TWO;
  assign prod  = mul_x * mul_y;
  assign sh    = {rem_q, quo_q[31]};
  assign diff  = sh - {1'b0, den_q};

  // operator precedence test for an incoming operator against the stack top
  assign do_reduce = (ocnt_q != '0) && (otop_q != iee_pkg::OP_OPEN) &&
                     ((iee_pkg::prec_of(otop_q) > iee_pkg::prec_of(tok_q.op)) ||
                      ((iee_pkg::prec_of(otop_q) == iee_pkg::prec_of(tok_q.op)) &&
                       (tok_q.op != iee_pkg::OP_POW)));

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    err_d       = err_q;
    tok_d       = tok_q;
    opc_d       = opc_q;
    vcnt_d      = vcnt_q;
    ocnt_d      = ocnt_q;
    out_valid_d = out_valid_q;
    res_val_d   = res_val_q;
    res_sts_d   = res_sts_q;
    b_d         = b_q;
    r_d         = r_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    base_d      = base_q;
    e_d         = e_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    tok_pop_o   = 1'b0;
    v_we        = 1'b0;
    v_waddr     = vcnt_q[AW-1:0];
    v_wdata     = r_q;
    v_raddr     = '0;
    o_we        = 1'b0;
    o_waddr     = ocnt_q[AW-1:0];
    o_wdata     = tok_q.op;
    o_ld        = 1'b0;
    o_byp       = 1'b0;
    o_raddr     = otop2[AW-1:0];
    mul_x       = vrd_q;
    mul_y       = b_q;

    if (out_valid_q && !res_stall_i) out_valid_d = 1'b0;

    unique case (state_q)
      iee_pkg::ST_IDLE: begin
        if (tok_valid_i) begin
          tok_pop_o = 1'b1;
          tok_d     = tok_i;
          state_d   = iee_pkg::ST_DISPATCH;
        end
      end
      iee_pkg::ST_DISPATCH: begin
        state_d = iee_pkg::ST_END;
        if (err_q == iee_pkg::STS_OK) begin
          unique case (tok_q.kind)
            iee_pkg::TK_DIGIT: begin
              if (vcnt_q >= FULL) begin
                err_d = iee_pkg::STS_OVERFLOW;
              end else begin
                v_we    = 1'b1;
                v_wdata = {28'd0, tok_q.digit};
                vcnt_d  = vcnt_q + ONE;
              end
            end
            iee_pkg::TK_OPEN: begin
              if (ocnt_q >= FULL) begin
                err_d = iee_pkg::STS_OVERFLOW;
              end else begin
                o_we    = 1'b1;
                o_wdata = iee_pkg::OP_OPEN;
                o_ld    = 1'b1;
                o_byp   = 1'b1;
                ocnt_d  = ocnt_q + ONE;
              end
            end
            iee_pkg::TK_CLOSE: state_d = iee_pkg::ST_CLOSE;
            iee_pkg::TK_OP:    state_d = iee_pkg::ST_OPSCAN;
            default:           err_d   = iee_pkg::STS_MALFORMED;
          endcase
        end
      end
      iee_pkg::ST_END: begin
        state_d = tok_q.last ? iee_pkg::ST_FIN : iee_pkg::ST_IDLE;
      end
      iee_pkg::ST_CLOSE: begin
        priority if (err_q != iee_pkg::STS_OK) begin
          state_d = iee_pkg::ST_END;
        end else if (ocnt_q == '0) begin
          err_d   = iee_pkg::STS_MALFORMED;
          state_d = iee_pkg::ST_END;
        end else if (otop_q == iee_pkg::OP_OPEN) begin
          ocnt_d  = ocnt_q - ONE;
          o_ld    = 1'b1;
          state_d = iee_pkg::ST_END;
        end else begin
          ret_d   = iee_pkg::ST_CLOSE;
          state_d = iee_pkg::ST_RED0;
        end
      end
      iee_pkg::ST_OPSCAN: begin
        priority if (err_q != iee_pkg::STS_OK) begin
          state_d = iee_pkg::ST_END;
        end else if (do_reduce) begin
          ret_d   = iee_pkg::ST_OPSCAN;
          state_d = iee_pkg::ST_RED0;
        end else begin
          state_d = iee_pkg::ST_END;
          if (ocnt_q >= FULL) begin
            err_d = iee_pkg::STS_OVERFLOW;
          end else begin
            o_we   = 1'b1;
            o_ld   = 1'b1;
            o_byp  = 1'b1;
            ocnt_d = ocnt_q + ONE;
          end
        end
      end
      iee_pkg::ST_FIN: begin
        priority if (err_q != iee_pkg::STS_OK) begin
          state_d = iee_pkg::ST_RESULT;
        end else if (ocnt_q != '0) begin
          if (otop_q == iee_pkg::OP_OPEN) begin
            err_d   = iee_pkg::STS_MALFORMED;
            state_d = iee_pkg::ST_RESULT;
          end else begin
            ret_d   = iee_pkg::ST_FIN;
            state_d = iee_pkg::ST_RED0;
          end
        end else begin
          if (vcnt_q != ONE) err_d = iee_pkg::STS_MALFORMED;
          state_d = iee_pkg::ST_RESULT;
        end
      end
      iee_pkg::ST_RESULT: begin
        // vrd_q holds the bottom of the value stack here
        if (!out_valid_q || !res_stall_i) begin
          out_valid_d = 1'b1;
          res_val_d   = (err_q == iee_pkg::STS_OK) ? vrd_q : 32'd0;
          res_sts_d   = err_q;
          err_d       = iee_pkg::STS_OK;
          vcnt_d      = '0;
          ocnt_d      = '0;
          state_d     = iee_pkg::ST_IDLE;
        end
      end
      iee_pkg::ST_RED0: begin
        opc_d  = otop_q;
        ocnt_d = ocnt_q - ONE;
        o_ld   = 1'b1;
        if (vcnt_q < TWO) begin
          err_d   = iee_pkg::STS_MALFORMED;
          state_d = ret_q;
        end else begin
          v_raddr = vtop1[AW-1:0];
          state_d = iee_pkg::ST_RED1;
        end
      end
      iee_pkg::ST_RED1: begin
        b_d     = vrd_q;
        v_raddr = vtop2[AW-1:0];
        state_d = iee_pkg::ST_RED2;
      end
      iee_pkg::ST_RED2: begin
        // left operand now in vrd_q
        vcnt_d  = vtop2;
        state_d = iee_pkg::ST_WR;
        unique case (opc_q)
          iee_pkg::OP_ADD: r_d = vrd_q + b_q;
          iee_pkg::OP_SUB: r_d = vrd_q - b_q;
          iee_pkg::OP_MUL: r_d = prod;
          iee_pkg::OP_DIV: begin
            if (b_q == 32'd0) begin
              err_d   = iee_pkg::STS_DIV0;
              state_d = ret_q;
            end else begin
              neg_d   = vrd_q[31] ^ b_q[31];
              quo_d   = vrd_q[31] ? -vrd_q : vrd_q;
              den_d   = b_q[31] ? -b_q : b_q;
              rem_d   = 32'd0;
              cnt_d   = 5'd0;
              state_d = iee_pkg::ST_DIV;
            end
          end
          iee_pkg::OP_POW: begin
            if (b_q[31]) begin
              priority if (vrd_q == 32'd1) r_d = 32'd1;
              else if (vrd_q == 32'hFFFF_FFFF) r_d = b_q[0] ? 32'hFFFF_FFFF : 32'd1;
              else r_d = 32'd0;
            end else begin
              acc_d   = 32'd1;
              base_d  = vrd_q;
              e_d     = b_q;
              cnt_d   = 5'd0;
              phase_d = 1'b0;
              state_d = iee_pkg::ST_POW;
            end
          end
          default: begin
            err_d   = iee_pkg::STS_MALFORMED;
            state_d = ret_q;
          end
        endcase
      end
      iee_pkg::ST_DIV: begin
        if (!diff[32]) begin
          rem_d = diff[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = sh[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) state_d = iee_pkg::ST_DIVFIN;
      end
      iee_pkg::ST_DIVFIN: begin
        r_d     = neg_q ? -quo_q : quo_q;
        state_d = iee_pkg::ST_WR;
      end
      iee_pkg::ST_POW: begin
        // even phase: multiply in the exponent bit, odd phase: square the base
        if (!phase_q) begin
          mul_x = acc_q;
          mul_y = base_q;
          if (e_q[0]) acc_d = prod;
          phase_d = 1'b1;
        end else begin
          mul_x   = base_q;
          mul_y   = base_q;
          base_d  = prod;
          e_d     = {1'b0, e_q[31:1]};
          phase_d = 1'b0;
          cnt_d   = cnt_q + 5'd1;
          if (cnt_q == POW_LAST) begin
            r_d     = acc_q;
            state_d = iee_pkg::ST_WR;
          end
        end
      end
      iee_pkg::ST_WR: begin
        v_we    = 1'b1;
        vcnt_d  = vcnt_q + ONE;
        state_d = ret_q;
      end
      default: state_d = iee_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iee_pkg::ST_IDLE;
      ret_q       <= iee_pkg::ST_IDLE;
      err_q       <= iee_pkg::STS_OK;
      vcnt_q      <= '0;
      ocnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      err_q       <= err_d;
      vcnt_q      <= vcnt_d;
      ocnt_q      <= ocnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q     <= tok_d;
    opc_q     <= opc_d;
    res_val_q <= res_val_d;
    res_sts_q <= res_sts_d;
    b_q       <= b_d;
    r_q       <= r_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    acc_q     <= acc_d;
    base_q    <= base_d;
    e_q       <= e_d;
    cnt_q     <= cnt_d;
    phase_q   <= phase_d;
  end

  always_ff @(posedge clk_i) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    vrd_q <= vmem[v_raddr];
  end

  // otop_q tracks the operator stack top; a push bypasses the memory
  always_ff @(posedge clk_i) begin
    if (o_we) omem[o_waddr] <= o_wdata;
    if (o_ld) otop_q <= o_byp ? o_wdata : omem[o_raddr];
  end

  assign res_valid_o    = out_valid_q;
  assign result_value_o = res_val_q;
  assign status_o       = res_sts_q;

endmodule

[design/infix_expression_evaluator.sv]
// Infix expression evaluator: one character per beat, one result per expression.
// A digit or opening parenthesis passes IDLE, DISPATCH and END in the back end,
// the final one also FIN and RESULT; each reduction adds RED0, RED1, RED2 and WR, plus
// a 32-step divider or 31 square-and-multiply steps on one shared multiplier (power).
// A two-entry token queue lets input beats arrive while a reduction runs.
// Reset (async, active low) empties the queue and both stacks and clears the error status.
module infix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sym_valid_i,
  output logic               sym_stall_o,
  input  logic [7:0]         symbol_i,
  input  logic               end_of_expression_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o
);

  iee_pkg::token_t tok;
  logic            tok_valid, tok_pop;

  iee_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sym_valid_i         (sym_valid_i),
    .sym_stall_o         (sym_stall_o),
    .symbol_i            (symbol_i),
    .end_of_expression_i (end_of_expression_i),
    .tok_valid_o         (tok_valid),
    .tok_pop_i           (tok_pop),
    .tok_o               (tok)
  );

  iee_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tok_valid_i    (tok_valid),
    .tok_pop_o      (tok_pop),
    .tok_i          (tok),
    .res_valid_o    (res_valid_o),
    .res_stall_i    (res_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

endmodule
